// ===== sv/scheduled_light_dimmer_macros.svh =====
// Assertion macros used by the dimmer's checker file.
`ifndef SCHEDULED_LIGHT_DIMMER_MACROS_SVH
`define SCHEDULED_LIGHT_DIMMER_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define SLD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("dimmer check failed");

// Concurrent assertion that is also checked during reset.
`define SLD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dimmer reset check failed");

`endif

// ===== sv/sld_pkg.sv =====
// Shared types, constants and microcode encodings of the light dimmer.
`default_nettype none

package sld_pkg;

    localparam int NUM_PHASES = 8;
    localparam int PHASE_W    = $clog2(NUM_PHASES);
    localparam int OP_W       = 3;
    localparam int MIN_W      = 11;
    localparam int LEVEL_W    = 10;
    localparam int DUTY_W     = 10;
    localparam int MODE_W     = 2;
    localparam int CFG_W      = 10;
    localparam int CFG_INDEX_W = 4;
    localparam int ACC_W      = 21;
    localparam int QUO_W      = 10;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int PC_W       = 5;

    localparam int PWM_TOP      = 1023;
    localparam int PWM_HIGH_MIN = PWM_TOP - 10;
    localparam int MAX_LEVEL    = 1000;

    // The duty is level * PWM_TOP / MAX_LEVEL, taken by a reciprocal multiplication.
    localparam int DUTY_SHIFT   = 30;
    localparam int DUTY_RECIP   = ((1 << DUTY_SHIFT) + MAX_LEVEL - 1) / MAX_LEVEL;
    localparam int DUTY_RECIP_W = 21;
    localparam int PROD_W       = ACC_W + DUTY_RECIP_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = LEVEL_W'(MAX_LEVEL);
    localparam logic [CFG_W-1:0]   ADJUST_RESET = CFG_W'(200);
    localparam logic [CFG_W-1:0]   FADE_RESET   = CFG_W'(10);
    localparam logic [PHASE_W-1:0] NIGHT_PHASE  = PHASE_W'(NUM_PHASES - 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_ADJUST_STEP = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_NIGHT_FADE  = CFG_INDEX_W'(1);

    localparam logic [OP_W-1:0] OP_TICK  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_LIGHT = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SCHED = OP_W'(2);
    localparam logic [OP_W-1:0] OP_UP    = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DOWN  = OP_W'(4);

    localparam logic [MODE_W-1:0] DRIVE_LOW  = MODE_W'(0);
    localparam logic [MODE_W-1:0] DRIVE_HIGH = MODE_W'(1);
    localparam logic [MODE_W-1:0] DRIVE_PWM  = MODE_W'(2);

    localparam logic [MIN_W-1:0] PHASE_START [NUM_PHASES] = '{
        MIN_W'(7 * 60 + 30), MIN_W'(9 * 60 + 30), MIN_W'(12 * 60 + 30),
        MIN_W'(17 * 60), MIN_W'(18 * 60 + 30), MIN_W'(19 * 60 + 30),
        MIN_W'(23 * 60), MIN_W'(23 * 60 + 15)
    };

    localparam logic [LEVEL_W-1:0] PHASE_LEVEL [NUM_PHASES] = '{
        LEVEL_W'(10), LEVEL_W'(700), LEVEL_W'(1000), LEVEL_W'(900),
        LEVEL_W'(900), LEVEL_W'(250), LEVEL_W'(100), LEVEL_W'(0)
    };

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [MIN_W-1:0] minute_of_day;
    } in_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]  drive_mode;
        logic [DUTY_W-1:0]  pwm_duty;
        logic               light_is_on;
        logic               schedule_is_on;
        logic [PHASE_W-1:0] phase_now;
        logic [LEVEL_W-1:0] level_now;
    } out_item_t;

    typedef enum logic [3:0] {
        UOP_NOP        = 4'd0,
        UOP_LOAD       = 4'd1,
        UOP_TOG_LIGHT  = 4'd2,
        UOP_TOG_SCHED  = 4'd3,
        UOP_STEP_UP    = 4'd4,
        UOP_STEP_DOWN  = 4'd5,
        UOP_FIND       = 4'd6,
        UOP_MUL_A      = 4'd7,
        UOP_MUL_B      = 4'd8,
        UOP_DIV_STEP   = 4'd9,
        UOP_BLEND_DONE = 4'd10,
        UOP_NIGHT      = 4'd11,
        UOP_DUTY_LOAD  = 4'd12,
        UOP_EMIT       = 4'd13,
        UOP_DUTY_MUL   = 4'd14
    } uop_t;

    typedef enum logic [3:0] {
        C_NEXT      = 4'd0,
        C_ALWAYS    = 4'd1,
        C_OP_TICK   = 4'd2,
        C_OP_LIGHT  = 4'd3,
        C_OP_SCHED  = 4'd4,
        C_OP_UP     = 4'd5,
        C_OP_DOWN   = 4'd6,
        C_SCHED_OFF = 4'd7,
        C_NIGHT     = 4'd8,
        C_CNT_NZ    = 4'd9
    } cond_t;

    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            wait_in;
        logic            wait_out;
    } ucode_t;

    typedef struct packed {
        uop_t uop;
        logic fire;
    } dp_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sched_on;
        logic            night;
        logic            cnt_nz;
        logic            out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/sld_ucode_rom.sv =====
// Read-only microcode program of the dimmer sequencer.
`default_nettype none

module sld_ucode_rom
    import sld_pkg::*;
(
    input  wire logic [PC_W-1:0] pc,
    output ucode_t               word
);

    localparam logic [PC_W-1:0] A_IDLE  = PC_W'(0);
    localparam logic [PC_W-1:0] A_LIGHT = PC_W'(7);
    localparam logic [PC_W-1:0] A_UP    = PC_W'(8);
    localparam logic [PC_W-1:0] A_DOWN  = PC_W'(9);
    localparam logic [PC_W-1:0] A_SCHED = PC_W'(10);
    localparam logic [PC_W-1:0] A_FIND  = PC_W'(11);
    localparam logic [PC_W-1:0] A_BDIV  = PC_W'(15);
    localparam logic [PC_W-1:0] A_NIGHT = PC_W'(17);
    localparam logic [PC_W-1:0] A_DUTY  = PC_W'(18);
    localparam logic [PC_W-1:0] A_DMUL  = PC_W'(19);
    localparam logic [PC_W-1:0] A_EMIT  = PC_W'(20);

    function automatic ucode_t uw(uop_t u, cond_t c, logic [PC_W-1:0] t,
                                  logic wi, logic wo);
        ucode_t w;
        w.uop      = u;
        w.cond     = c;
        w.target   = t;
        w.wait_in  = wi;
        w.wait_out = wo;
        return w;
    endfunction

    always_comb begin
        unique case (pc)
            A_IDLE:     word = uw(UOP_LOAD, C_NEXT, A_IDLE, 1'b1, 1'b0);
            PC_W'(1):   word = uw(UOP_NOP, C_OP_TICK, A_FIND, 1'b0, 1'b0);
            PC_W'(2):   word = uw(UOP_NOP, C_OP_LIGHT, A_LIGHT, 1'b0, 1'b0);
            PC_W'(3):   word = uw(UOP_NOP, C_OP_SCHED, A_SCHED, 1'b0, 1'b0);
            PC_W'(4):   word = uw(UOP_NOP, C_OP_UP, A_UP, 1'b0, 1'b0);
            PC_W'(5):   word = uw(UOP_NOP, C_OP_DOWN, A_DOWN, 1'b0, 1'b0);
            PC_W'(6):   word = uw(UOP_NOP, C_ALWAYS, A_DUTY, 1'b0, 1'b0);
            A_LIGHT:    word = uw(UOP_TOG_LIGHT, C_ALWAYS, A_DUTY, 1'b0, 1'b0);
            A_UP:       word = uw(UOP_STEP_UP, C_ALWAYS, A_DUTY, 1'b0, 1'b0);
            A_DOWN:     word = uw(UOP_STEP_DOWN, C_ALWAYS, A_DUTY, 1'b0, 1'b0);
            A_SCHED:    word = uw(UOP_TOG_SCHED, C_NEXT, A_IDLE, 1'b0, 1'b0);
            A_FIND:     word = uw(UOP_FIND, C_SCHED_OFF, A_DUTY, 1'b0, 1'b0);
            PC_W'(12):  word = uw(UOP_NOP, C_NIGHT, A_NIGHT, 1'b0, 1'b0);
            PC_W'(13):  word = uw(UOP_MUL_A, C_NEXT, A_IDLE, 1'b0, 1'b0);
            PC_W'(14):  word = uw(UOP_MUL_B, C_NEXT, A_IDLE, 1'b0, 1'b0);
            A_BDIV:     word = uw(UOP_DIV_STEP, C_CNT_NZ, A_BDIV, 1'b0, 1'b0);
            PC_W'(16):  word = uw(UOP_BLEND_DONE, C_ALWAYS, A_DUTY, 1'b0, 1'b0);
            A_NIGHT:    word = uw(UOP_NIGHT, C_NEXT, A_IDLE, 1'b0, 1'b0);
            A_DUTY:     word = uw(UOP_DUTY_LOAD, C_NEXT, A_IDLE, 1'b0, 1'b0);
            A_DMUL:     word = uw(UOP_DUTY_MUL, C_NEXT, A_IDLE, 1'b0, 1'b0);
            A_EMIT:     word = uw(UOP_EMIT, C_ALWAYS, A_IDLE, 1'b0, 1'b1);
            default:    word = uw(UOP_NOP, C_ALWAYS, A_IDLE, 1'b0, 1'b0);
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sld_sequencer.sv =====
// Step counter of the dimmer with wait handling and conditional jumps.
`default_nettype none

module sld_sequencer
    import sld_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire dp_stat_t stat,
    output logic          in_ready,
    output dp_ctrl_t      ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            stall;
    logic            take;

    sld_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    always_comb begin
        unique case (word.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_OP_TICK:   take = (stat.op == OP_TICK);
            C_OP_LIGHT:  take = (stat.op == OP_LIGHT);
            C_OP_SCHED:  take = (stat.op == OP_SCHED);
            C_OP_UP:     take = (stat.op == OP_UP);
            C_OP_DOWN:   take = (stat.op == OP_DOWN);
            C_SCHED_OFF: take = !stat.sched_on;
            C_NIGHT:     take = stat.night;
            C_CNT_NZ:    take = stat.cnt_nz;
            default:     take = 1'b0;
        endcase
    end

    assign stall    = (word.wait_in && !s_valid) || (word.wait_out && !stat.out_free);
    assign in_ready = word.wait_in;
    assign ctrl.uop  = word.uop;
    assign ctrl.fire = !stall;

    always_comb begin
        priority if (stall) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sld_datapath.sv =====
// Dimmer datapath: state, configuration, phase search, blend and divider.
`default_nettype none

module sld_datapath
    import sld_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dp_ctrl_t               ctrl,
    input  wire in_item_t               s_item,
    input  wire logic                   m_ready,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    output dp_stat_t                    stat,
    output logic                        m_valid,
    output out_item_t                   m_result
);

    in_item_t           item_reg,   item_next;
    logic [LEVEL_W-1:0] level_reg,  level_next;
    logic               light_reg,  light_next;
    logic               sched_reg,  sched_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [CFG_W-1:0]   adjust_reg, fade_reg;
    logic [MIN_W-1:0]   elap_reg,   elap_next;
    logic [MIN_W-1:0]   div_reg,    div_next;
    logic [ACC_W-1:0]   acc_reg,    acc_next;
    logic [QUO_W-1:0]   quo_reg,    quo_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    out_item_t          out_reg,    out_next;
    logic               mv_reg,     mv_next;

    logic [PHASE_W-1:0] find_phase;
    logic [MIN_W-1:0]   find_elap;
    logic [MIN_W-1:0]   find_span;
    logic [ACC_W-1:0]   div_shift;
    logic               div_fit;
    logic [LEVEL_W:0]   up_sum;
    logic [LEVEL_W-1:0] bi, bn;
    logic [MODE_W-1:0]  mode;
    logic [PROD_W-1:0]  duty_prod;

    always_comb begin
        find_phase = NIGHT_PHASE;
        find_elap  = '0;
        find_span  = MIN_W'(1);
        for (int i = 0; i < NUM_PHASES - 1; i++) begin
            if (item_reg.minute_of_day >= PHASE_START[i]
                && item_reg.minute_of_day < PHASE_START[i+1]) begin
                find_phase = PHASE_W'(i);
                find_elap  = item_reg.minute_of_day - PHASE_START[i];
                find_span  = PHASE_START[i+1] - PHASE_START[i];
            end
        end
    end

    assign bi        = PHASE_LEVEL[phase_reg];
    assign bn        = (phase_reg == NIGHT_PHASE) ? PHASE_LEVEL[0]
                                                  : PHASE_LEVEL[phase_reg + PHASE_W'(1)];
    assign div_shift = ACC_W'(div_reg) << cnt_reg;
    assign div_fit   = (acc_reg >= div_shift);
    assign up_sum    = {1'b0, level_reg} + {1'b0, adjust_reg};
    assign duty_prod = PROD_W'(acc_reg) * PROD_W'(DUTY_RECIP);

    always_comb begin
        priority if (quo_reg <= DUTY_W'(1)) begin
            mode = DRIVE_LOW;
        end else if (quo_reg >= DUTY_W'(PWM_HIGH_MIN)) begin
            mode = DRIVE_HIGH;
        end else begin
            mode = DRIVE_PWM;
        end
    end

    always_comb begin
        item_next  = item_reg;
        level_next = level_reg;
        light_next = light_reg;
        sched_next = sched_reg;
        phase_next = phase_reg;
        elap_next  = elap_reg;
        div_next   = div_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_ready;
        if (ctrl.fire) begin
            unique case (ctrl.uop)
                UOP_NOP: begin
                end
                UOP_LOAD: begin
                    item_next = s_item;
                end
                UOP_TOG_LIGHT: begin
                    light_next = !light_reg;
                end
                UOP_TOG_SCHED: begin
                    sched_next = !sched_reg;
                end
                UOP_STEP_UP: begin
                    level_next = (up_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                               : up_sum[LEVEL_W-1:0];
                    light_next = (up_sum != '0);
                end
                UOP_STEP_DOWN: begin
                    level_next = (level_reg > adjust_reg) ? level_reg - adjust_reg : '0;
                    light_next = (level_reg > adjust_reg);
                end
                UOP_FIND: begin
                    phase_next = find_phase;
                    elap_next  = find_elap;
                    div_next   = find_span;
                end
                UOP_MUL_A: begin
                    acc_next = ACC_W'(bi) * ACC_W'(div_reg - elap_reg);
                end
                UOP_MUL_B: begin
                    acc_next = acc_reg + ACC_W'(bn) * ACC_W'(elap_reg);
                    quo_next = '0;
                    cnt_next = CNT_W'(QUO_W - 1);
                end
                UOP_DIV_STEP: begin
                    acc_next = div_fit ? acc_reg - div_shift : acc_reg;
                    quo_next = {quo_reg[QUO_W-2:0], div_fit};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                UOP_BLEND_DONE: begin
                    level_next = (quo_reg > LEVEL_MAX) ? LEVEL_MAX : quo_reg;
                    light_next = 1'b1;
                end
                UOP_NIGHT: begin
                    level_next = (level_reg > fade_reg) ? level_reg - fade_reg : '0;
                    light_next = (level_reg > fade_reg);
                end
                UOP_DUTY_LOAD: begin
                    acc_next = light_reg ? ACC_W'(level_reg) * ACC_W'(PWM_TOP) : '0;
                end
                UOP_DUTY_MUL: begin
                    quo_next = duty_prod[DUTY_SHIFT +: QUO_W];
                end
                UOP_EMIT: begin
                    out_next.drive_mode     = mode;
                    out_next.pwm_duty       = quo_reg;
                    out_next.light_is_on    = light_reg;
                    out_next.schedule_is_on = sched_reg;
                    out_next.phase_now      = phase_reg;
                    out_next.level_now      = level_reg;
                    mv_next                 = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            light_reg  <= 1'b0;
            sched_reg  <= 1'b1;
            phase_reg  <= '0;
            adjust_reg <= ADJUST_RESET;
            fade_reg   <= FADE_RESET;
            mv_reg     <= 1'b0;
        end else begin
            level_reg <= level_next;
            light_reg <= light_next;
            sched_reg <= sched_next;
            phase_reg <= phase_next;
            mv_reg    <= mv_next;
            if (cfg_we && cfg_index == CFG_ADJUST_STEP) begin
                adjust_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_NIGHT_FADE) begin
                fade_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        elap_reg <= elap_next;
        div_reg  <= div_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    assign stat.op       = item_reg.op;
    assign stat.sched_on = sched_reg;
    assign stat.night    = (phase_reg == NIGHT_PHASE);
    assign stat.cnt_nz   = (cnt_reg != '0);
    assign stat.out_free = !mv_reg || m_ready;
    assign m_valid       = mv_reg;
    assign m_result      = out_reg;

endmodule

`default_nettype wire

// ===== sv/scheduled_light_dimmer.sv =====
// Top level of the scheduled light dimmer.
//
// The input channel (s_valid, s_ready, s_item) carries one item per transfer:
// a minute tick or a button command with the current minute of the day. The
// result channel (m_valid, m_ready, m_result) returns exactly one result per
// item: pin drive mode, PWM duty, both enable flags, the phase and the level.
// The configuration port writes adjust_step (index 0) or night_fade_step
// (index 1) whenever cfg_we is high; other indexes are ignored.
// A microcoded sequencer runs every item through one shared datapath, so
// items are taken one at a time. A scheduled blend, on a tick or on a toggle
// that turns the schedule on, runs through the ten-step restoring divider,
// which makes it the longest path of the program. The next item is taken once
// the result is registered. The result is held in an output register, and
// the next item is taken while it waits. If the receiver stalls, the block
// stops at its last step until the held result is taken. Reset sets level 0,
// light off, schedule on, phase 0 and the register defaults of 200 and 10,
// and leaves the result channel empty.
`default_nettype none

module scheduled_light_dimmer
    import sld_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_item,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    sld_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .stat     (stat),
        .in_ready (s_ready),
        .ctrl     (ctrl)
    );

    sld_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .s_item    (s_item),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_result  (m_result)
    );

endmodule

`default_nettype wire

// ===== sv/sld_checker.sv =====
// Port checker of the light dimmer and its bind to the top level.
`default_nettype none
`include "scheduled_light_dimmer_macros.svh"

module sld_checker
    import sld_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_result
);

    `SLD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
    `SLD_ASSERT(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_result))
    `SLD_ASSERT(a_level_range, aclk, aresetn, m_valid |-> m_result.level_now <= LEVEL_MAX)
    `SLD_ASSERT(a_low_mode, aclk, aresetn, m_valid |-> (m_result.drive_mode == DRIVE_LOW) == (m_result.pwm_duty <= DUTY_W'(1)))
    `SLD_ASSERT(a_off_dark, aclk, aresetn, m_valid && !m_result.light_is_on |-> m_result.pwm_duty == '0)

endmodule

bind scheduled_light_dimmer sld_checker u_sld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

`default_nettype wire
